[rtl/core/svpwm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types and constants of the SVPWM compare generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam logic [14:0] SQRT3_Q14 = 15'h6ED9;
  localparam logic [13:0] HP_RESET  = 14'd3600;
  localparam int          S_SHIFT   = 14;
  localparam logic [28:0] S_RESET_FULL = 29'(SQRT3_Q14 * HP_RESET);
  localparam logic [14:0] S_RESET   = S_RESET_FULL[28:14];

  typedef logic [2:0] sector_t;

  localparam sector_t SEC_ZERO = 3'd0;
  localparam sector_t SEC_1    = 3'd1;
  localparam sector_t SEC_2    = 3'd2;
  localparam sector_t SEC_3    = 3'd3;
  localparam sector_t SEC_4    = 3'd4;
  localparam sector_t SEC_5    = 3'd5;
  localparam sector_t SEC_6    = 3'd6;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } vec_t;

  typedef struct packed {
    logic signed [16:0] u1;
    logic signed [16:0] u2;
    logic signed [16:0] u3;
    sector_t            sector;
  } proj_t;

  typedef struct packed {
    logic [15:0] ta;
    logic [15:0] tb;
    sector_t     sector;
  } active_t;

  typedef struct packed {
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    sector_t     sector;
  } cmp_t;

  // bit0: u1 >= 0, bit1: u2 >= 0, bit2: u3 >= 0
  function automatic sector_t sector_of(input logic [2:0] signs);
    sector_t s;
    unique case (signs)
      3'd0:    s = SEC_ZERO;
      3'd1:    s = SEC_2;
      3'd2:    s = SEC_6;
      3'd3:    s = SEC_1;
      3'd4:    s = SEC_4;
      3'd5:    s = SEC_3;
      3'd6:    s = SEC_5;
      default: s = SEC_ZERO;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/core/svpwm_compare_generator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while m_axis_tready is held high; six register
//   stages, each with its own valid bit, and a stage advances whenever the one
//   after it has room.
// Reset: clears all valid bits and sets half_period to 3600.
// ----------------------------------------------------------------------------
// svpwm_compare_generator_top
// Center-aligned SVPWM: (alpha, beta) in, three compare values and sector out.
// ----------------------------------------------------------------------------
module svpwm_compare_generator_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [13:0] cfg_wdata,      // half_period
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // alpha[15:0], beta[31:16]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata    // compare_a[15:0], compare_b[31:16],
                                      // compare_c[47:32], sector[50:48], zero pad
);

  logic [13:0]        half_period;
  logic [14:0]        s_scale;
  logic [28:0]        s_prod;
  svpwm_pkg::vec_t    in_vec;
  logic               pv, pr, av, ar;
  svpwm_pkg::proj_t   proj;
  svpwm_pkg::active_t act;
  svpwm_pkg::cmp_t    res;

  assign s_prod = svpwm_pkg::SQRT3_Q14 * cfg_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= svpwm_pkg::HP_RESET;
      s_scale     <= svpwm_pkg::S_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
      s_scale     <= s_prod[28:14];
    end
  end

  assign in_vec.alpha = s_axis_tdata[15:0];
  assign in_vec.beta  = s_axis_tdata[31:16];

  svpwm_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_vec),
    .out_valid (pv),
    .out_ready (pr),
    .out_data  (proj)
  );

  svpwm_active u_active (
    .clk       (clk),
    .rst       (rst),
    .s_scale   (s_scale),
    .in_valid  (pv),
    .in_ready  (pr),
    .in_data   (proj),
    .out_valid (av),
    .out_ready (ar),
    .out_data  (act)
  );

  svpwm_compare u_compare (
    .clk         (clk),
    .rst         (rst),
    .half_period (half_period),
    .in_valid    (av),
    .in_ready    (ar),
    .in_data     (act),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (res)
  );

  assign m_axis_tdata = {5'b00000, res.sector, res.compare_c, res.compare_b, res.compare_a};

endmodule
`default_nettype wire

[rtl/core/svpwm_sector.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_sector
// Two stages: alpha scaling by sqrt3/2, then u1/u2/u3 and sector decode.
// ----------------------------------------------------------------------------
module svpwm_sector (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire svpwm_pkg::vec_t in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output svpwm_pkg::proj_t  out_data
);

  logic               v1, v2;
  logic               en1, en2;
  logic signed [31:0] pa;
  logic signed [15:0] beta1;
  logic signed [31:0] npa;
  logic signed [16:0] bh;
  logic signed [16:0] u1_next, u2_next, u3_next;
  svpwm_pkg::proj_t   r2;

  assign en2      = ~v2 | out_ready;
  assign en1      = ~v1 | en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      pa    <= $signed({1'b0, svpwm_pkg::SQRT3_Q14}) * in_data.alpha;
      beta1 <= in_data.beta;
    end
  end

  always_comb begin
    npa     = 32'sd0 - pa;
    bh      = {{2{beta1[15]}}, beta1[15:1]};
    u1_next = {beta1[15], beta1};
    u2_next = $signed(pa[31:15]) - bh;
    u3_next = $signed(npa[31:15]) - bh;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      r2.u1     <= u1_next;
      r2.u2     <= u2_next;
      r2.u3     <= u3_next;
      r2.sector <= svpwm_pkg::sector_of({~u3_next[16], ~u2_next[16], ~u1_next[16]});
    end
  end

  assign out_valid = v2;
  assign out_data  = r2;

endmodule
`default_nettype wire

[rtl/core/svpwm_active.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_active
// Two stages: operand select and S*u products, then sign and Q15 scaling.
// ----------------------------------------------------------------------------
module svpwm_active (
  input  wire                clk,
  input  wire                rst,
  input  wire  [14:0]        s_scale,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire svpwm_pkg::proj_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output svpwm_pkg::active_t out_data
);

  logic                 v1, v2;
  logic                 en1, en2;
  logic signed [16:0]   ua, ub;
  logic                 neg;
  logic signed [32:0]   pa, pb;
  logic                 neg1;
  svpwm_pkg::sector_t   sec1;
  logic signed [32:0]   qa, qb;
  svpwm_pkg::active_t   r2;

  assign en2      = ~v2 | out_ready;
  assign en1      = ~v1 | en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_comb begin
    ua  = in_data.u2;
    ub  = in_data.u1;
    neg = 1'b0;
    unique case (in_data.sector)
      svpwm_pkg::SEC_1: begin ua = in_data.u2; ub = in_data.u1; neg = 1'b0; end
      svpwm_pkg::SEC_2: begin ua = in_data.u2; ub = in_data.u3; neg = 1'b1; end
      svpwm_pkg::SEC_3: begin ua = in_data.u1; ub = in_data.u3; neg = 1'b0; end
      svpwm_pkg::SEC_4: begin ua = in_data.u1; ub = in_data.u2; neg = 1'b1; end
      svpwm_pkg::SEC_5: begin ua = in_data.u3; ub = in_data.u2; neg = 1'b0; end
      svpwm_pkg::SEC_6: begin ua = in_data.u3; ub = in_data.u1; neg = 1'b1; end
      default: begin ua = in_data.u2; ub = in_data.u1; neg = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      pa   <= $signed({1'b0, s_scale}) * ua;
      pb   <= $signed({1'b0, s_scale}) * ub;
      neg1 <= neg;
      sec1 <= in_data.sector;
    end
  end

  // floor shift by 15 keeps bits [30:15] of the (possibly negated) product
  always_comb begin
    qa = neg1 ? (33'sd0 - pa) : pa;
    qb = neg1 ? (33'sd0 - pb) : pb;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      r2.ta     <= qa[30:15];
      r2.tb     <= qb[30:15];
      r2.sector <= sec1;
    end
  end

  assign out_valid = v2;
  assign out_data  = r2;

endmodule
`default_nettype wire

[rtl/core/svpwm_compare.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_compare
// Two stages: zero time, then channel accumulation in sector order.
// ----------------------------------------------------------------------------
module svpwm_compare (
  input  wire                clk,
  input  wire                rst,
  input  wire  [13:0]        half_period,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire svpwm_pkg::active_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output svpwm_pkg::cmp_t    out_data
);

  logic               v1, v2;
  logic               en1, en2;
  logic [16:0]        diff;
  logic [15:0]        tz, ta1, tb1;
  svpwm_pkg::sector_t sec1;
  logic [15:0]        lo, mid, hi, hp16;
  svpwm_pkg::cmp_t    r_next, r2;

  assign en2      = ~v2 | out_ready;
  assign en1      = ~v1 | en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  assign diff = {3'b000, half_period} - {1'b0, in_data.ta} - {1'b0, in_data.tb};

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      tz   <= diff[16:1];
      ta1  <= in_data.ta;
      tb1  <= in_data.tb;
      sec1 <= in_data.sector;
    end
  end

  always_comb begin
    hp16   = {2'b00, half_period};
    lo     = tz;
    mid    = tz + tb1;
    hi     = mid + ta1;
    r_next = '{compare_a: hp16, compare_b: hp16, compare_c: hp16, sector: sec1};
    unique case (sec1)
      svpwm_pkg::SEC_1: begin
        r_next.compare_a = hi;  r_next.compare_b = mid; r_next.compare_c = lo;
      end
      svpwm_pkg::SEC_2: begin
        r_next.compare_a = mid; r_next.compare_b = hi;  r_next.compare_c = lo;
      end
      svpwm_pkg::SEC_3: begin
        r_next.compare_a = lo;  r_next.compare_b = hi;  r_next.compare_c = mid;
      end
      svpwm_pkg::SEC_4: begin
        r_next.compare_a = lo;  r_next.compare_b = mid; r_next.compare_c = hi;
      end
      svpwm_pkg::SEC_5: begin
        r_next.compare_a = mid; r_next.compare_b = lo;  r_next.compare_c = hi;
      end
      svpwm_pkg::SEC_6: begin
        r_next.compare_a = hi;  r_next.compare_b = lo;  r_next.compare_c = mid;
      end
      default: begin
        r_next.compare_a = hp16; r_next.compare_b = hp16; r_next.compare_c = hp16;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) r2 <= r_next;
  end

  assign out_valid = v2;
  assign out_data  = r2;

endmodule
`default_nettype wire
